[design/first_match_ip_access_list_assert.svh]
// Assertion macros used by the access list RTL.
`ifndef FIRST_MATCH_IP_ACCESS_LIST_ASSERT_SVH
`define FIRST_MATCH_IP_ACCESS_LIST_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define FMACL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define FMACL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fmacl_pkg.sv]
// Shared constants, codes and widths of the first-match access list.
package fmacl_pkg;

	// Default list depths
	localparam int V4_RULES_DEF = 16;
	localparam int V6_RULES_DEF = 16;

	// Operation codes
	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [1:0] FUNC_CHECK  = 2'd2;

	// Address family codes
	localparam logic [1:0] FAM_V4    = 2'd0;
	localparam logic [1:0] FAM_V6    = 2'd1;
	localparam logic [1:0] FAM_LOCAL = 2'd2;

	// Verdict codes
	localparam logic [1:0] VERDICT_DECLINED  = 2'd0;
	localparam logic [1:0] VERDICT_ALLOWED   = 2'd1;
	localparam logic [1:0] VERDICT_FORBIDDEN = 2'd2;

	// Stream widths
	localparam int IN_DATA_W  = 264;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 8;

	// Rule entry widths: IPv4 {deny, mask, addr}, IPv6 {deny, mask_lo, mask_hi, addr_lo, addr_hi}
	localparam int V4_ENTRY_W = 65;
	localparam int V6_ENTRY_W = 257;

	// IPv4-mapped IPv6 marker in bits 63..32 of the low half
	localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

	function automatic logic [1:0] decide(input logic deny_bit);
		return deny_bit ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
	endfunction

endpackage

[design/fmacl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fmacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/first_match_ip_access_list.sv]
// Top level of the first-match IPv4/IPv6/local-socket access list.
`include "first_match_ip_access_list_assert.svh"

// Each item appends a rule, clears all lists, checks a connection or, with an unused
// code, does nothing, and gives exactly one result item. IPv4 and IPv6 rules sit in
// one RAM each and the local-socket rule in registers; a check reads its list one
// rule per cycle in order, as each RAM has a single read port, and stops at the first
// match. Append, clear, local-socket checks and checks against an empty list skip
// the scan and go straight to the result state.
// The next item is taken once the result is in the output register, even if that
// result is not yet taken. There is no clearing pass: the rule counts bound every read.
module first_match_ip_access_list #(
	parameter int V4_RULES = fmacl_pkg::V4_RULES_DEF,
	parameter int V6_RULES = fmacl_pkg::V6_RULES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// addr_hi [63:0], addr_lo [127:64], mask_hi [191:128], mask_lo [255:192],
	// deny [256], zero [263:257]
	input  logic [fmacl_pkg::IN_DATA_W-1:0]  s_tdata,
	// func [1:0], family [3:2]
	input  logic [fmacl_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// verdict [1:0], table_full [2], zero [7:3]
	output logic [fmacl_pkg::OUT_DATA_W-1:0] m_tdata
);

	import fmacl_pkg::*;

	localparam int V4_AW = (V4_RULES > 1) ? $clog2(V4_RULES) : 1;
	localparam int V6_AW = (V6_RULES > 1) ? $clog2(V6_RULES) : 1;
	localparam int V4_CW = $clog2(V4_RULES + 1);
	localparam int V6_CW = $clog2(V6_RULES + 1);
	localparam int IDX_W = (V4_CW > V6_CW) ? V4_CW : V6_CW;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESP} state_t;

	state_t           state_q;
	logic [V4_CW-1:0] v4_cnt_q;
	logic [V6_CW-1:0] v6_cnt_q;
	logic             local_present_q;
	logic             local_deny_q;
	logic [IDX_W-1:0] idx_q;
	logic             pend_s1;
	logic             use_v6_q;
	logic [63:0]      cl_hi_q;
	logic [63:0]      cl_lo_q;
	logic [1:0]       verdict_q;
	logic             full_q;
	logic             m_valid_q;
	logic [1:0]       m_verdict_q;
	logic             m_full_q;

	// Input fields
	logic [1:0]  func;
	logic [1:0]  family;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [63:0] mask_hi;
	logic [63:0] mask_lo;
	logic        deny;

	assign func    = s_tuser[1:0];
	assign family  = s_tuser[3:2];
	assign addr_hi = s_tdata[63:0];
	assign addr_lo = s_tdata[127:64];
	assign mask_hi = s_tdata[191:128];
	assign mask_lo = s_tdata[255:192];
	assign deny    = s_tdata[256];

	logic acc;
	logic v4_room;
	logic v6_room;
	logic mapped;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign v4_room  = v4_cnt_q < V4_CW'(V4_RULES);
	assign v6_room  = v6_cnt_q < V6_CW'(V6_RULES);
	assign mapped   = (addr_hi == 64'd0) && (addr_lo[63:32] == V4_MAPPED_TAG);

	// Decode the item: which list to scan, a direct local verdict, a dropped append
	logic       scan_v4;
	logic       scan_v6;
	logic [1:0] local_verdict;
	logic       append_full;

	assign scan_v4 = (func == FUNC_CHECK) && (v4_cnt_q != '0) &&
	                 ((family == FAM_V4) || ((family == FAM_V6) && mapped));
	assign scan_v6 = (func == FUNC_CHECK) && (family == FAM_V6) &&
	                 !(mapped && (v4_cnt_q != '0)) && (v6_cnt_q != '0);
	assign local_verdict = ((func == FUNC_CHECK) && (family == FAM_LOCAL) && local_present_q) ?
	                       decide(local_deny_q) : VERDICT_DECLINED;
	assign append_full = (func == FUNC_APPEND) &&
	                     (((family == FAM_V4) && !v4_room) || ((family == FAM_V6) && !v6_room));

	// Rule memories
	logic                  v4_we;
	logic                  v6_we;
	logic                  v4_re;
	logic                  v6_re;
	logic [V4_ENTRY_W-1:0] v4_rd;
	logic [V6_ENTRY_W-1:0] v6_rd;
	logic                  issue;

	assign v4_we = acc && (func == FUNC_APPEND) && (family == FAM_V4) && v4_room;
	assign v6_we = acc && (func == FUNC_APPEND) && (family == FAM_V6) && v6_room;
	assign v4_re = issue && !use_v6_q;
	assign v6_re = issue && use_v6_q;

	fmacl_ram #(.WIDTH(V4_ENTRY_W), .DEPTH(V4_RULES)) u_v4_ram (
		.clk   (clk),
		.we    (v4_we),
		.waddr (v4_cnt_q[V4_AW-1:0]),
		.wdata ({deny, mask_lo[31:0], addr_lo[31:0]}),
		.re    (v4_re),
		.raddr (idx_q[V4_AW-1:0]),
		.rdata (v4_rd)
	);

	fmacl_ram #(.WIDTH(V6_ENTRY_W), .DEPTH(V6_RULES)) u_v6_ram (
		.clk   (clk),
		.we    (v6_we),
		.waddr (v6_cnt_q[V6_AW-1:0]),
		.wdata ({deny, mask_lo, mask_hi, addr_lo, addr_hi}),
		.re    (v6_re),
		.raddr (idx_q[V6_AW-1:0]),
		.rdata (v6_rd)
	);

	// Compare the rule read last cycle against the client
	logic             match4;
	logic             match6;
	logic             hit;
	logic             hit_deny;
	logic [IDX_W-1:0] cur_cnt;
	logic             more;

	assign match4   = (cl_lo_q[31:0] & v4_rd[63:32]) == v4_rd[31:0];
	assign match6   = ((cl_hi_q & v6_rd[191:128]) == v6_rd[63:0]) &&
	                  ((cl_lo_q & v6_rd[255:192]) == v6_rd[127:64]);
	assign hit      = pend_s1 && (use_v6_q ? match6 : match4);
	assign hit_deny = use_v6_q ? v6_rd[256] : v4_rd[64];
	assign cur_cnt  = use_v6_q ? IDX_W'(v6_cnt_q) : IDX_W'(v4_cnt_q);
	assign more     = idx_q < cur_cnt;
	assign issue    = (state_q == ST_SCAN) && !hit && more;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'({m_full_q, m_verdict_q});

	// Sequence each item: update lists, scan, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			v4_cnt_q        <= '0;
			v6_cnt_q        <= '0;
			local_present_q <= 1'b0;
			local_deny_q    <= 1'b0;
			idx_q           <= '0;
			pend_s1         <= 1'b0;
			use_v6_q        <= 1'b0;
			cl_hi_q         <= '0;
			cl_lo_q         <= '0;
			verdict_q       <= VERDICT_DECLINED;
			full_q          <= 1'b0;
			m_valid_q       <= 1'b0;
			m_verdict_q     <= VERDICT_DECLINED;
			m_full_q        <= 1'b0;
		end else begin
			pend_s1 <= issue;
			// Drop the result once taken, unless a new one moves in
			if (m_valid_q && m_tready && (state_q != ST_RESP)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						verdict_q <= local_verdict;
						full_q    <= append_full;
						cl_hi_q   <= addr_hi;
						cl_lo_q   <= addr_lo;
						idx_q     <= '0;
						use_v6_q  <= scan_v6;
						state_q   <= (scan_v4 || scan_v6) ? ST_SCAN : ST_RESP;
						case (func)
							FUNC_APPEND: begin
								case (family)
									FAM_V4: begin
										if (v4_room) begin
											v4_cnt_q <= v4_cnt_q + 1'b1;
										end
									end
									FAM_V6: begin
										if (v6_room) begin
											v6_cnt_q <= v6_cnt_q + 1'b1;
										end
									end
									FAM_LOCAL: begin
										if (!local_present_q) begin
											local_present_q <= 1'b1;
											local_deny_q    <= deny;
										end
									end
									default: ;
								endcase
							end
							FUNC_CLEAR: begin
								v4_cnt_q        <= '0;
								v6_cnt_q        <= '0;
								local_present_q <= 1'b0;
								local_deny_q    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						verdict_q <= decide(hit_deny);
						state_q   <= ST_RESP;
					end else if (more) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q   <= 1'b1;
						m_verdict_q <= verdict_q;
						m_full_q    <= full_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FMACL_ASSERT_SAME(a_cnt_bound, 1'b1,
		(v4_cnt_q <= V4_CW'(V4_RULES)) && (v6_cnt_q <= V6_CW'(V6_RULES)),
		"rule count exceeds list depth")
	`FMACL_ASSERT_SAME(a_pend_in_scan, pend_s1, state_q == ST_SCAN,
		"rule read pending outside a scan")
	`FMACL_ASSERT_SAME(a_idx_bound, state_q == ST_SCAN, idx_q <= cur_cnt,
		"scan index ran past the rule count")
	`FMACL_ASSERT_NEXT(a_hit_resp, (state_q == ST_SCAN) && hit, state_q == ST_RESP,
		"first match did not end the scan")
	`FMACL_ASSERT_SAME(a_out_excl, m_valid_q,
		!(m_full_q && (m_verdict_q != VERDICT_DECLINED)),
		"result flags both a dropped append and a check verdict")

endmodule

[test/tb_first_match_ip_access_list.sv]
// Self-checking stream testbench for the first-match IP access list.
module tb_first_match_ip_access_list;
	import fmacl_pkg::*;

	localparam int V4_DEPTH = V4_RULES_DEF;
	localparam int V6_DEPTH = V6_RULES_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] FAM_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_START = 1500;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int RUN_LIMIT = 200000;

	typedef struct {
		logic [1:0]  func;
		logic [1:0]  family;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [63:0] mask_hi;
		logic [63:0] mask_lo;
		logic        deny;
	} access_item_t;

	typedef struct {
		logic [1:0] verdict;
		logic       table_full;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	first_match_ip_access_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Predicted contents of the three rule lists
	logic [31:0]  acl_v4_addr [V4_DEPTH];
	logic [31:0]  acl_v4_mask [V4_DEPTH];
	logic         acl_v4_deny [V4_DEPTH];
	int           acl_v4_count = 0;
	logic [127:0] acl_v6_addr [V6_DEPTH];
	logic [127:0] acl_v6_mask [V6_DEPTH];
	logic         acl_v6_deny [V6_DEPTH];
	int           acl_v6_count = 0;
	logic         acl_local_present = 1'b0;
	logic         acl_local_deny = 1'b0;

	// Rules the generator has appended, used to aim clients at them
	logic [31:0]  pool_v4_addr [V4_DEPTH];
	logic [31:0]  pool_v4_mask [V4_DEPTH];
	int           pool_v4_n = 0;
	logic [127:0] pool_v6_addr [V6_DEPTH];
	logic [127:0] pool_v6_mask [V6_DEPTH];
	int           pool_v6_n = 0;
	int           random_counted = 0;

	access_item_t   pending_items [$];
	access_result_t expected_verdicts [$];
	access_item_t   offered_item;
	access_result_t oldest_verdict;
	int             items_accepted = 0;
	int             burst_left = 1;
	int             gap_left = 0;
	int             ready_cycle = 0;
	int             cycle_count = 0;
	int             failures = 0;

	function automatic logic [1:0] first_v4_verdict(logic [31:0] client);
		for (int i = 0; i < acl_v4_count; i++) begin
			if ((client & acl_v4_mask[i]) == acl_v4_addr[i])
				return acl_v4_deny[i] ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
		end
		return VERDICT_DECLINED;
	endfunction

	function automatic logic [1:0] first_v6_verdict(logic [127:0] client);
		for (int i = 0; i < acl_v6_count; i++) begin
			if ((client & acl_v6_mask[i]) == acl_v6_addr[i])
				return acl_v6_deny[i] ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
		end
		return VERDICT_DECLINED;
	endfunction

	// Apply one item to the predicted lists and return its verdict
	function automatic access_result_t judge_item(access_item_t it);
		access_result_t r;
		logic mapped;
		r.verdict = VERDICT_DECLINED;
		r.table_full = 1'b0;
		mapped = (it.addr_hi == 64'd0) && (it.addr_lo[63:32] == V4_MAPPED_TAG);
		case (it.func)
			FUNC_APPEND: begin
				case (it.family)
					FAM_V4: begin
						if (acl_v4_count < V4_DEPTH) begin
							acl_v4_addr[acl_v4_count] = it.addr_lo[31:0];
							acl_v4_mask[acl_v4_count] = it.mask_lo[31:0];
							acl_v4_deny[acl_v4_count] = it.deny;
							acl_v4_count++;
						end else begin
							r.table_full = 1'b1;
						end
					end
					FAM_V6: begin
						if (acl_v6_count < V6_DEPTH) begin
							acl_v6_addr[acl_v6_count] = {it.addr_hi, it.addr_lo};
							acl_v6_mask[acl_v6_count] = {it.mask_hi, it.mask_lo};
							acl_v6_deny[acl_v6_count] = it.deny;
							acl_v6_count++;
						end else begin
							r.table_full = 1'b1;
						end
					end
					FAM_LOCAL: begin
						// only the first local-socket rule counts
						if (!acl_local_present) begin
							acl_local_present = 1'b1;
							acl_local_deny = it.deny;
						end
					end
					default: ;
				endcase
			end
			FUNC_CLEAR: begin
				acl_v4_count = 0;
				acl_v6_count = 0;
				acl_local_present = 1'b0;
				acl_local_deny = 1'b0;
			end
			FUNC_CHECK: begin
				case (it.family)
					FAM_V4: r.verdict = first_v4_verdict(it.addr_lo[31:0]);
					FAM_V6: begin
						// a mapped IPv4 client prefers the IPv4 list when it has rules
						if (mapped && acl_v4_count != 0)
							r.verdict = first_v4_verdict(it.addr_lo[31:0]);
						else
							r.verdict = first_v6_verdict({it.addr_hi, it.addr_lo});
					end
					FAM_LOCAL: begin
						if (acl_local_present)
							r.verdict = acl_local_deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_item(logic [1:0] f, logic [1:0] fam, logic [63:0] ahi,
			logic [63:0] alo, logic [63:0] mhi, logic [63:0] mlo, logic d);
		access_item_t it;
		it.func = f;
		it.family = fam;
		it.addr_hi = ahi;
		it.addr_lo = alo;
		it.mask_hi = mhi;
		it.mask_lo = mlo;
		it.deny = d;
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [1:0] rand_code();
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic logic [31:0] prefix32(int len);
		return (len == 0) ? 32'd0 : ~32'd0 << (32 - len);
	endfunction

	function automatic logic [127:0] prefix128(int len);
		return (len == 0) ? 128'd0 : ~128'd0 << (128 - len);
	endfunction

	task automatic queue_v4_rule();
		logic [31:0] m;
		logic [31:0] a;
		m = ($urandom_range(0, 7) == 0) ? $urandom : prefix32($urandom_range(0, 32));
		// now and then leave address bits outside the mask
		a = ($urandom_range(0, 9) == 0) ? $urandom : ($urandom & m);
		queue_item(FUNC_APPEND, FAM_V4, rand64(), {$urandom, a}, rand64(), {$urandom, m},
			rand_bit());
		if (pool_v4_n < V4_DEPTH) begin
			pool_v4_addr[pool_v4_n] = a;
			pool_v4_mask[pool_v4_n] = m;
			pool_v4_n++;
		end
	endtask

	task automatic queue_v6_rule();
		logic [127:0] m;
		logic [127:0] a;
		m = ($urandom_range(0, 7) == 0) ? {rand64(), rand64()} :
			prefix128($urandom_range(0, 128));
		a = ($urandom_range(0, 9) == 0) ? {rand64(), rand64()} : ({rand64(), rand64()} & m);
		queue_item(FUNC_APPEND, FAM_V6, a[127:64], a[63:0], m[127:64], m[63:0],
			rand_bit());
		if (pool_v6_n < V6_DEPTH) begin
			pool_v6_addr[pool_v6_n] = a;
			pool_v6_mask[pool_v6_n] = m;
			pool_v6_n++;
		end
	endtask

	function automatic logic [31:0] v4_client();
		int r;
		if (pool_v4_n > 0 && $urandom_range(0, 9) < 7) begin
			r = $urandom_range(0, pool_v4_n - 1);
			return pool_v4_addr[r] | ($urandom & ~pool_v4_mask[r]);
		end
		return $urandom;
	endfunction

	function automatic logic [127:0] v6_client();
		int r;
		if (pool_v6_n > 0 && $urandom_range(0, 9) < 7) begin
			r = $urandom_range(0, pool_v6_n - 1);
			return pool_v6_addr[r] | ({rand64(), rand64()} & ~pool_v6_mask[r]);
		end
		return {rand64(), rand64()};
	endfunction

	task automatic queue_random_check();
		int sel;
		logic [127:0] c;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			queue_item(FUNC_CHECK, FAM_V4, rand64(), {$urandom, v4_client()}, rand64(),
				rand64(), rand_bit());
		end else if (sel < 7) begin
			c = v6_client();
			queue_item(FUNC_CHECK, FAM_V6, c[127:64], c[63:0], rand64(), rand64(),
				rand_bit());
		end else if (sel < 9) begin
			// IPv4-mapped client
			queue_item(FUNC_CHECK, FAM_V6, 64'd0, {V4_MAPPED_TAG, v4_client()}, rand64(),
				rand64(), rand_bit());
		end else begin
			queue_item(FUNC_CHECK, FAM_LOCAL, rand64(), rand64(), rand64(), rand64(),
				rand_bit());
		end
	endtask

	task automatic queue_noise_item();
		if ($urandom_range(0, 1) == 0)
			queue_item(FUNC_UNUSED, rand_code(), rand64(), rand64(), rand64(),
				rand64(), rand_bit());
		else
			queue_item($urandom_range(0, 1) ? FUNC_APPEND : FUNC_CHECK, FAM_UNUSED, rand64(),
				rand64(), rand64(), rand64(), rand_bit());
	endtask

	// Clear most of the time, append a random rule set, then check clients
	task automatic queue_random_session();
		int n_rules;
		int n_checks;
		int sel;
		if ($urandom_range(0, 9) < 7) begin
			queue_item(FUNC_CLEAR, rand_code(), rand64(), rand64(), rand64(),
				rand64(), rand_bit());
			pool_v4_n = 0;
			pool_v6_n = 0;
			random_counted++;
		end
		n_rules = $urandom_range(0, 36);
		for (int i = 0; i < n_rules; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 9)
				queue_v4_rule();
			else if (sel < 18)
				queue_v6_rule();
			else
				queue_item(FUNC_APPEND, FAM_LOCAL, rand64(), rand64(), rand64(), rand64(),
					rand_bit());
			random_counted++;
		end
		n_checks = $urandom_range(4, 20);
		for (int i = 0; i < n_checks; i++) begin
			queue_random_check();
			random_counted++;
		end
		if ($urandom_range(0, 3) == 0)
			queue_noise_item();
	endtask

	task automatic queue_directed_items();
		// empty lists decline every family
		queue_item(FUNC_CHECK, FAM_V4, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, '1, '1, '1, '1, 1'b1);
		queue_item(FUNC_CHECK, FAM_LOCAL, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_UNUSED, '1, '1, '1, '1, 1'b1);
		// IPv4 rules: junk above bit 31, an unmatchable rule, a deny-all
		queue_item(FUNC_APPEND, FAM_V4, '1, 64'hDEAD_BEEF_0A00_0000, '1,
			64'h1234_5678_FF00_0000, 1'b0);
		queue_item(FUNC_APPEND, FAM_V4, 64'd0, 64'h0000_0000_0B00_00FF, 64'd0,
			64'h0000_0000_FFFF_FF00, 1'b0);
		queue_item(FUNC_APPEND, FAM_V4, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
		queue_item(FUNC_CHECK, FAM_V4, 64'd0, 64'hFFFF_FFFF_0A01_0203, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V4, 64'd0, 64'h0000_0000_0B00_00FF, 64'd0, 64'd0, 1'b0);
		// IPv6 rules: a denied /32 and an allowed all-ones host
		queue_item(FUNC_APPEND, FAM_V6, 64'h2001_0DB8_0000_0000, 64'd0,
			64'hFFFF_FFFF_0000_0000, 64'd0, 1'b1);
		queue_item(FUNC_APPEND, FAM_V6, '1, '1, '1, '1, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, 64'h2001_0DB8_0000_0000, 64'd1, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, '1, '1, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, 64'hFE80_0000_0000_0000, 64'd1, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, 64'd0, {V4_MAPPED_TAG, 32'h0A01_0203}, 64'd0, 64'd0,
			1'b0);
		// only the first local-socket rule decides
		queue_item(FUNC_APPEND, FAM_LOCAL, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
		queue_item(FUNC_APPEND, FAM_LOCAL, '1, '1, '1, '1, 1'b0);
		queue_item(FUNC_CHECK, FAM_LOCAL, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_APPEND, FAM_UNUSED, '1, '1, '1, '1, 1'b1);
		queue_item(FUNC_UNUSED, FAM_V4, '1, '1, '1, '1, 1'b1);
		// after a clear a mapped client falls back to the IPv6 list
		queue_item(FUNC_CLEAR, FAM_V4, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, 64'd0, {V4_MAPPED_TAG, 32'h0A01_0203}, 64'd0, 64'd0,
			1'b0);
		queue_item(FUNC_APPEND, FAM_V6, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
		queue_item(FUNC_CHECK, FAM_V6, 64'd0, {V4_MAPPED_TAG, 32'h0A01_0203}, 64'd0, 64'd0,
			1'b0);
		queue_item(FUNC_CHECK, FAM_LOCAL, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
	endtask

	// Offer items in bursts; predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_verdicts.push_back(judge_item(offered_item));
				items_accepted <= items_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					offered_item = pending_items.pop_front();
					s_tdata <= {7'd0, offered_item.deny, offered_item.mask_lo,
						offered_item.mask_hi, offered_item.addr_lo, offered_item.addr_hi};
					s_tuser <= {offered_item.family, offered_item.func};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) :
							$urandom_range(1, 8);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side: one long hold-off, otherwise a rotating pattern
	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		if (ready_cycle >= HOLD_START && ready_cycle < HOLD_START + HOLD_LEN) begin
			m_tready <= 1'b0;
		end else begin
			case (ready_cycle[7:6])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= rand_bit();
				2'd2: m_tready <= (ready_cycle[1:0] != 2'd0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Compare each result item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result item: verdict %0d, table_full %0d",
					m_tdata[1:0], m_tdata[2]);
				failures++;
			end else begin
				oldest_verdict = expected_verdicts.pop_front();
				if (m_tdata[1:0] !== oldest_verdict.verdict) begin
					$error("verdict: expected %0d, got %0d", oldest_verdict.verdict,
						m_tdata[1:0]);
					failures++;
				end
				if (m_tdata[2] !== oldest_verdict.table_full) begin
					$error("table_full: expected %0d, got %0d", oldest_verdict.table_full,
						m_tdata[2]);
					failures++;
				end
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int total_items;
		queue_directed_items();
		while (random_counted < RANDOM_ITEMS)
			queue_random_session();
		total_items = pending_items.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (items_accepted < total_items)
			@(posedge clk);
		while (expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
